/* rtl/mas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg
// shared types, character codes and mode codes for the macro argument splitter
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;
  localparam int NEST_W = 8;
  localparam int MODE_W = 3;
  localparam int CLS_W  = 2;
  localparam int RUN_N  = 3;
  localparam int CNT_W  = 2;

  // group depth saturates here
  localparam logic [NEST_W-1:0] MAX_NEST = 8'd255;

  // scan modes
  localparam logic [MODE_W-1:0] MODE_PLAIN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUOTE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QPEND = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BPEND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GROUP = 3'd4;

  // class of the last character seen
  localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SPACE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_COMMA = 2'd2;
  localparam logic [CLS_W-1:0] CLS_TEXT  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST_END = 2'd2;

  // characters of interest
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
  } res_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              arg_open;
    logic [NEST_W-1:0] depth;
  } scan_stat_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* rtl/mas_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_scan
// scanner state and per-character decode into a run of up to three results
// ----------------------------------------------------------------------------
module mas_scan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  logic [mas_pkg::CHAR_W-1:0]            text_char,
  input  logic                                  is_end,
  output logic [mas_pkg::CNT_W-1:0]             run_cnt,
  output mas_pkg::res_t [mas_pkg::RUN_N-1:0]    run,
  output mas_pkg::scan_stat_t                   stat
);
  import mas_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              open_r, open_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [NEST_W-1:0] depth_r, depth_nxt;
  logic              brk_r, brk_nxt;

  always_comb begin
    logic [CNT_W-1:0]  n;
    logic              plain_go;
    logic              quote_go;
    logic [CHAR_W-1:0] g_open;
    logic [CHAR_W-1:0] g_close;

    n         = '0;
    run       = '0;
    plain_go  = 1'b0;
    quote_go  = 1'b0;
    mode_nxt  = mode_r;
    open_nxt  = open_r;
    cls_nxt   = cls_r;
    depth_nxt = depth_r;
    brk_nxt   = brk_r;
    g_open    = brk_r ? CH_LBRACK : CH_LPAREN;
    g_close   = brk_r ? CH_RBRACK : CH_RPAREN;

    if (is_end) begin
      if (mode_r == MODE_BPEND) begin
        run[n].kind = KIND_CHAR;
        run[n].ch   = CH_BSLASH;
        n           = n + 2'd1;
      end
      if (open_r || (cls_r == CLS_COMMA)) begin
        run[n].kind = KIND_ARG_END;
        n           = n + 2'd1;
      end
      run[n].kind = KIND_LIST_END;
      n           = n + 2'd1;
      mode_nxt    = MODE_PLAIN;
      open_nxt    = 1'b0;
      cls_nxt     = CLS_NONE;
      depth_nxt   = '0;
      brk_nxt     = 1'b0;
    end else begin
      case (mode_r)
        MODE_QUOTE: begin
          quote_go = 1'b1;
        end
        MODE_QPEND: begin
          if (text_char == CH_QUOTE) begin
            run[n].kind = KIND_CHAR;
            run[n].ch   = CH_QUOTE;
            n           = n + 2'd1;
            mode_nxt    = MODE_QUOTE;
          end else begin
            plain_go = 1'b1;
          end
        end
        MODE_BPEND: begin
          if (text_char == CH_QUOTE) begin
            run[n].kind = KIND_CHAR;
            run[n].ch   = CH_QUOTE;
            n           = n + 2'd1;
            mode_nxt    = MODE_QUOTE;
          end else begin
            run[n].kind = KIND_CHAR;
            run[n].ch   = CH_BSLASH;
            n           = n + 2'd1;
            quote_go    = 1'b1;
          end
        end
        MODE_GROUP: begin
          if (text_char == g_open) begin
            if (depth_r < MAX_NEST) depth_nxt = depth_r + 1'b1;
          end else if (text_char == g_close) begin
            if (depth_r != '0) depth_nxt = depth_r - 1'b1;
          end
          run[n].kind = KIND_CHAR;
          run[n].ch   = text_char;
          n           = n + 2'd1;
          if (depth_nxt == '0) mode_nxt = MODE_PLAIN;
        end
        default: begin
          plain_go = 1'b1;
        end
      endcase

      // quoted text: a quote or backslash is held pending
      if (quote_go) begin
        mode_nxt = MODE_QUOTE;
        if (text_char == CH_QUOTE) begin
          mode_nxt = MODE_QPEND;
        end else if (text_char == CH_BSLASH) begin
          mode_nxt = MODE_BPEND;
        end else begin
          run[n].kind = KIND_CHAR;
          run[n].ch   = text_char;
          n           = n + 2'd1;
        end
      end

      // plain text outside quote and group
      if (plain_go) begin
        mode_nxt = MODE_PLAIN;
        if (text_char == CH_QUOTE) begin
          mode_nxt = MODE_QUOTE;
          open_nxt = 1'b1;
          cls_nxt  = CLS_TEXT;
        end else if ((text_char == CH_LPAREN) || (text_char == CH_LBRACK)) begin
          mode_nxt    = MODE_GROUP;
          brk_nxt     = (text_char == CH_LBRACK);
          depth_nxt   = {{(NEST_W-1){1'b0}}, 1'b1};
          run[n].kind = KIND_CHAR;
          run[n].ch   = text_char;
          n           = n + 2'd1;
          open_nxt    = 1'b1;
          cls_nxt     = CLS_TEXT;
        end else if (text_char == CH_COMMA) begin
          if (open_r) begin
            run[n].kind = KIND_ARG_END;
            n           = n + 2'd1;
            open_nxt    = 1'b0;
          end else if ((cls_r == CLS_COMMA) || (cls_r == CLS_NONE)) begin
            run[n].kind = KIND_ARG_END;
            n           = n + 2'd1;
          end
          cls_nxt = CLS_COMMA;
        end else if (is_blank(text_char)) begin
          if (open_r) begin
            run[n].kind = KIND_ARG_END;
            n           = n + 2'd1;
            open_nxt    = 1'b0;
            cls_nxt     = CLS_SPACE;
          end
        end else begin
          run[n].kind = KIND_CHAR;
          run[n].ch   = text_char;
          n           = n + 2'd1;
          open_nxt    = 1'b1;
          cls_nxt     = CLS_TEXT;
        end
      end
    end

    run_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      open_r  <= 1'b0;
      cls_r   <= CLS_NONE;
      depth_r <= '0;
      brk_r   <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      open_r  <= open_nxt;
      cls_r   <= cls_nxt;
      depth_r <= depth_nxt;
      brk_r   <= brk_nxt;
    end
  end

  assign stat.mode     = mode_r;
  assign stat.arg_open = open_r;
  assign stat.depth    = depth_r;

endmodule

/* rtl/mas_drain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_drain
// result register holding one item's run, shifted out one beat per cycle while out_stall is low
// ----------------------------------------------------------------------------
module mas_drain (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [mas_pkg::CNT_W-1:0]             run_cnt,
  input  mas_pkg::res_t [mas_pkg::RUN_N-1:0]    run,
  input  logic                                  out_stall,
  output logic                                  take_ok,
  output logic                                  out_valid,
  output mas_pkg::res_t                         out_res,
  output logic                                  out_last
);
  import mas_pkg::*;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  res_t [RUN_N-1:0]       slot_r, slot_nxt;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  // free once the last beat of the current run leaves
  assign take_ok   = (cnt_r == '0) || ((cnt_r == 2'd1) && pop);
  assign out_res   = slot_r[0];
  assign out_last  = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    if (load) begin
      cnt_nxt  = run_cnt;
      slot_nxt = run;
    end else if (pop) begin
      cnt_nxt     = cnt_r - 2'd1;
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

/* rtl/macro_argument_splitter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macro_argument_splitter_top
// splits an operand line, one character per beat, into macro argument events
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_text_char, in_is_end
//  out_     output     out_valid/out_stall  out_event_kind, out_arg_char,
//                                           out_last_of_run
//
//  an input beat is decoded in the cycle it is taken and its run of zero to
//  three results lands in the result register at the same edge
//  results leave one beat per cycle while out_stall is low; an item giving
//  one result or none is taken every cycle while out_stall is low; for longer runs,
//  the next beat is taken while the last result of the run is being taken
//  rst_n is synchronous; scanner state returns to plain, no argument open
//  out_stall only holds the result register; the scanner waits via in_stall
// ----------------------------------------------------------------------------
module macro_argument_splitter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mas_pkg::CHAR_W-1:0]    in_text_char,
  input  logic                          in_is_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mas_pkg::KIND_W-1:0]    out_event_kind,
  output logic [mas_pkg::CHAR_W-1:0]    out_arg_char,
  output logic                          out_last_of_run
);
  import mas_pkg::*;

  logic                 in_fire;
  logic                 take_ok;
  logic [CNT_W-1:0]     run_cnt;
  res_t [RUN_N-1:0]     run;
  scan_stat_t           stat;
  res_t                 head;

  // stall whenever the result register still owes beats of an earlier run
  assign in_stall = !take_ok;
  assign in_fire  = in_valid && take_ok;

  // character decode and scanner state
  mas_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .text_char (in_text_char),
    .is_end    (in_is_end),
    .run_cnt   (run_cnt),
    .run       (run),
    .stat      (stat)
  );

  // result register and beat serialiser
  mas_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .run_cnt   (run_cnt),
    .run       (run),
    .out_stall (out_stall),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_res   (head),
    .out_last  (out_last_of_run)
  );

  assign out_event_kind = head.kind;
  assign out_arg_char   = head.ch;

  // the list-end mark always closes its run
  a_list_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == KIND_LIST_END)) |-> out_last_of_run)
    else $error("list end is not the last beat of its run");

  // an end item leaves the scanner back in plain mode with nothing open
  a_end_resets : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_is_end) |=> ((stat.mode == MODE_PLAIN) && !stat.arg_open
                                && (stat.depth == '0)))
    else $error("scanner state not cleared after end item");

  // a group is only open while its depth is non-zero
  a_group_depth : assert property (@(posedge clk) disable iff (!rst_n)
    (stat.mode == MODE_GROUP) |-> (stat.depth != '0))
    else $error("group mode with zero depth");

  // characters carry a value only on character beats
  a_char_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind != KIND_CHAR)) |-> (out_arg_char == '0))
    else $error("mark beat carries a character");

endmodule
